FILE: rtl/yuvrot_pkg.sv
package yuvrot_pkg;

  // Input and output field widths
  localparam int unsigned COORD_W  = 12;
  localparam int unsigned SAMPLE_W = 8;
  localparam int unsigned IDX_W    = 24;
  localparam int unsigned CIDX_W   = 25;
  localparam int unsigned PIXEL_W  = 32;

  // Configuration register widths
  localparam int unsigned DIMREG_W  = 13;
  localparam int unsigned CROW_W    = 15;
  localparam int unsigned CPIX_W    = 3;
  localparam int unsigned CFG_DATA_W = 15;

  // Color coefficients (Q10 for red/blue, Q17 for green)
  localparam logic [10:0] COEF_RV = 11'd1436;
  localparam logic [15:0] COEF_GU = 16'd46549;
  localparam logic [16:0] COEF_GV = 17'd93604;
  localparam logic [10:0] COEF_BU = 11'd1814;

  // Channel offsets
  localparam logic [7:0] OFS_R  = 8'd179;
  localparam logic [7:0] OFS_G0 = 8'd44;
  localparam logic [7:0] OFS_G1 = 8'd91;
  localparam logic [7:0] OFS_B  = 8'd227;
  localparam logic [7:0] ALPHA  = 8'd255;

  // Signed working width of a channel before clamping
  localparam int unsigned CHAN_W = 11;

  // Register reset values
  localparam logic [DIMREG_W-1:0] RST_FRAME_WIDTH  = 13'd640;
  localparam logic [DIMREG_W-1:0] RST_FRAME_HEIGHT = 13'd480;
  localparam logic [CROW_W-1:0]   RST_CROW_STRIDE  = 15'd640;
  localparam logic [CPIX_W-1:0]   RST_CPIX_STRIDE  = 3'd2;

  // Configuration register map
  typedef enum logic [1:0] {
    REG_FRAME_WIDTH   = 2'd0,
    REG_FRAME_HEIGHT  = 2'd1,
    REG_CROW_STRIDE   = 2'd2,
    REG_CPIX_STRIDE   = 2'd3
  } cfg_reg_t;

  // Per-stage load enables from the pipeline control
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } stage_en_t;

endpackage

FILE: rtl/yuvrot_ctrl.sv
module yuvrot_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  output yuvrot_pkg::stage_en_t  en
);

  logic v1;
  logic v2;
  logic v3;

  // A stage loads when it is empty or its content moves on
  always_comb begin
    en.s3 = !v3 || out_ready;
    en.s2 = !v2 || en.s3;
    en.s1 = !v1 || en.s2;
  end

  assign in_ready  = en.s1;
  assign out_valid = v3;

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en.s1) v1 <= in_valid;
      if (en.s2) v2 <= v1;
      if (en.s3) v3 <= v2;
    end
  end

endmodule

FILE: rtl/yuvrot_color.sv
module yuvrot_color (
  input  logic                                 clk,
  input  yuvrot_pkg::stage_en_t                en,
  input  logic [yuvrot_pkg::SAMPLE_W-1:0]      luma,
  input  logic [yuvrot_pkg::SAMPLE_W-1:0]      chroma_u,
  input  logic [yuvrot_pkg::SAMPLE_W-1:0]      chroma_v,
  output logic [yuvrot_pkg::PIXEL_W-1:0]       pixel_word
);

  localparam int unsigned CW = yuvrot_pkg::CHAN_W;

  // Stage 1: constant products, scaled
  logic [7:0]  y1;
  logic [8:0]  rv1;
  logic [6:0]  gu1;
  logic [7:0]  gv1;
  logic [8:0]  bu1;

  logic [18:0] rv_prod;
  logic [23:0] gu_prod;
  logic [24:0] gv_prod;
  logic [18:0] bu_prod;

  assign rv_prod = 19'(chroma_v) * 19'(yuvrot_pkg::COEF_RV);
  assign gu_prod = 24'(chroma_u) * 24'(yuvrot_pkg::COEF_GU);
  assign gv_prod = 25'(chroma_v) * 25'(yuvrot_pkg::COEF_GV);
  assign bu_prod = 19'(chroma_u) * 19'(yuvrot_pkg::COEF_BU);

  always_ff @(posedge clk) begin
    if (en.s1) begin
      y1  <= luma;
      rv1 <= rv_prod[18:10];
      gu1 <= gu_prod[23:17];
      gv1 <= gv_prod[24:17];
      bu1 <= bu_prod[18:10];
    end
  end

  // Stage 2: offsets, two's complement in CW bits
  logic [CW-1:0] rt2;
  logic [CW-1:0] gt2;
  logic [CW-1:0] bt2;

  always_ff @(posedge clk) begin
    if (en.s2) begin
      rt2 <= CW'(y1) + CW'(rv1) - CW'(yuvrot_pkg::OFS_R);
      gt2 <= CW'(y1) - CW'(gu1) - CW'(gv1)
             + CW'(yuvrot_pkg::OFS_G0) + CW'(yuvrot_pkg::OFS_G1);
      bt2 <= CW'(y1) + CW'(bu1) - CW'(yuvrot_pkg::OFS_B);
    end
  end

  // Clamp to 0..255: sign bit gives 0, any bit above 7 gives 255
  function automatic logic [7:0] clip8(input logic [CW-1:0] val);
    logic [7:0] res;
    if (val[CW-1])
      res = 8'd0;
    else if (val[CW-2:8] != '0)
      res = 8'd255;
    else
      res = val[7:0];
    return res;
  endfunction

  // Stage 3: clamp and pack into the output register
  always_ff @(posedge clk) begin
    if (en.s3) begin
      pixel_word <= {yuvrot_pkg::ALPHA, clip8(bt2), clip8(gt2), clip8(rt2)};
    end
  end

endmodule

FILE: rtl/yuvrot_addr.sv
module yuvrot_addr #(
  parameter int unsigned DIM_W = 13
) (
  input  logic                                clk,
  input  yuvrot_pkg::stage_en_t               en,
  input  logic [DIM_W-1:0]                    width_sat,
  input  logic [DIM_W-1:0]                    height_sat,
  input  logic [yuvrot_pkg::CROW_W-1:0]       crow_stride,
  input  logic [yuvrot_pkg::CPIX_W-1:0]       cpix_stride,
  input  logic [yuvrot_pkg::COORD_W-1:0]      column,
  input  logic [yuvrot_pkg::COORD_W-1:0]      row,
  output logic [yuvrot_pkg::IDX_W-1:0]        dest_index,
  output logic [yuvrot_pkg::IDX_W-1:0]        luma_index,
  output logic [yuvrot_pkg::CIDX_W-1:0]       chroma_index
);

  localparam int unsigned CRD = yuvrot_pkg::COORD_W;
  localparam int unsigned IW  = yuvrot_pkg::IDX_W;
  localparam int unsigned CIW = yuvrot_pkg::CIDX_W;
  localparam int unsigned DP_W = DIM_W + CRD + 1;
  localparam int unsigned LP_W = DIM_W + CRD;
  localparam int unsigned CP_W = yuvrot_pkg::CPIX_W + CRD - 1;
  localparam int unsigned CR_W = yuvrot_pkg::CROW_W + CRD - 1;
  localparam int unsigned CS_W = CR_W + 1;

  // Stage 1: the four products
  logic [DP_W-1:0] dest_prod;
  logic [LP_W-1:0] luma_prod;
  logic [CP_W-1:0] cpix_prod;
  logic [CR_W-1:0] crow_prod;

  assign dest_prod = DP_W'(height_sat) * (DP_W'(column) + DP_W'(1));
  assign luma_prod = LP_W'(row) * LP_W'(width_sat);
  assign cpix_prod = CP_W'(cpix_stride) * CP_W'(column[CRD-1:1]);
  assign crow_prod = CR_W'(crow_stride) * CR_W'(row[CRD-1:1]);

  logic [IW-1:0]  dest_p1;
  logic [IW-1:0]  luma_p1;
  logic [CRD:0]   row_p1;
  logic [CRD-1:0] col1;
  logic [CP_W-1:0] cpix1;
  logic [CR_W-1:0] crow1;

  always_ff @(posedge clk) begin
    if (en.s1) begin
      dest_p1 <= IW'(dest_prod);
      luma_p1 <= IW'(luma_prod);
      row_p1  <= (CRD+1)'(row) + (CRD+1)'(1);
      col1    <= column;
      cpix1   <= cpix_prod;
      crow1   <= crow_prod;
    end
  end

  // Stage 2: final adds and subtract, each wrapping at its field width
  logic [IW-1:0]  dest2;
  logic [IW-1:0]  luma2;
  logic [CIW-1:0] chroma2;
  logic [CS_W-1:0] csum;

  assign csum = CS_W'(cpix1) + CS_W'(crow1);

  always_ff @(posedge clk) begin
    if (en.s2) begin
      dest2   <= dest_p1 - IW'(row_p1);
      luma2   <= luma_p1 + IW'(col1);
      chroma2 <= CIW'(csum);
    end
  end

  // Stage 3: output register
  always_ff @(posedge clk) begin
    if (en.s3) begin
      dest_index   <= dest2;
      luma_index   <= luma2;
      chroma_index <= chroma2;
    end
  end

endmodule

FILE: rtl/yuv420_to_rgba_rotate_core.sv
// An accepted input beat is registered at the product, offset and clamp stages before its output beat.
// Throughput: one pixel per cycle while the output is not stalled; set by the three-stage multiply/add/clamp pipeline.
// A stalled output holds the pipeline in place; nothing is dropped or repeated.
// Reset (synchronous, active high) empties the pipeline and loads the
// configuration defaults: 640 x 480, chroma row stride 640, pixel stride 2.
module yuv420_to_rgba_rotate_core #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [1:0]                          cfg_index,
  input  logic [yuvrot_pkg::CFG_DATA_W-1:0]   cfg_data,
  // input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [yuvrot_pkg::COORD_W-1:0]      column,
  input  logic [yuvrot_pkg::COORD_W-1:0]      row,
  input  logic [yuvrot_pkg::SAMPLE_W-1:0]     luma,
  input  logic [yuvrot_pkg::SAMPLE_W-1:0]     chroma_u,
  input  logic [yuvrot_pkg::SAMPLE_W-1:0]     chroma_v,
  // output channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [yuvrot_pkg::PIXEL_W-1:0]      pixel_word,
  output logic [yuvrot_pkg::IDX_W-1:0]        dest_index,
  output logic [yuvrot_pkg::IDX_W-1:0]        luma_index,
  output logic [yuvrot_pkg::CIDX_W-1:0]       chroma_index
);

  localparam int unsigned DIM_W = $clog2(MAX_DIM + 1);
  localparam int unsigned CMP_W = yuvrot_pkg::DIMREG_W + 1;

  logic [yuvrot_pkg::DIMREG_W-1:0] frame_width;
  logic [yuvrot_pkg::DIMREG_W-1:0] frame_height;
  logic [yuvrot_pkg::CROW_W-1:0]   chroma_row_stride;
  logic [yuvrot_pkg::CPIX_W-1:0]   chroma_pixel_stride;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width         <= yuvrot_pkg::RST_FRAME_WIDTH;
      frame_height        <= yuvrot_pkg::RST_FRAME_HEIGHT;
      chroma_row_stride   <= yuvrot_pkg::RST_CROW_STRIDE;
      chroma_pixel_stride <= yuvrot_pkg::RST_CPIX_STRIDE;
    end else if (cfg_we) begin
      unique case (yuvrot_pkg::cfg_reg_t'(cfg_index))
        yuvrot_pkg::REG_FRAME_WIDTH:
          frame_width <= cfg_data[yuvrot_pkg::DIMREG_W-1:0];
        yuvrot_pkg::REG_FRAME_HEIGHT:
          frame_height <= cfg_data[yuvrot_pkg::DIMREG_W-1:0];
        yuvrot_pkg::REG_CROW_STRIDE:
          chroma_row_stride <= cfg_data[yuvrot_pkg::CROW_W-1:0];
        yuvrot_pkg::REG_CPIX_STRIDE:
          chroma_pixel_stride <= cfg_data[yuvrot_pkg::CPIX_W-1:0];
        default: ;
      endcase
    end
  end

  // Frame dimensions saturate at MAX_DIM
  logic [DIM_W-1:0] width_sat;
  logic [DIM_W-1:0] height_sat;

  always_comb begin
    if (CMP_W'(frame_width) > CMP_W'(MAX_DIM))
      width_sat = DIM_W'(MAX_DIM);
    else
      width_sat = DIM_W'(frame_width);
    if (CMP_W'(frame_height) > CMP_W'(MAX_DIM))
      height_sat = DIM_W'(MAX_DIM);
    else
      height_sat = DIM_W'(frame_height);
  end

  // Pipeline control
  yuvrot_pkg::stage_en_t en;

  yuvrot_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .en        (en)
  );

  // Color datapath
  yuvrot_color u_color (
    .clk        (clk),
    .en         (en),
    .luma       (luma),
    .chroma_u   (chroma_u),
    .chroma_v   (chroma_v),
    .pixel_word (pixel_word)
  );

  // Address datapath
  yuvrot_addr #(
    .DIM_W (DIM_W)
  ) u_addr (
    .clk          (clk),
    .en           (en),
    .width_sat    (width_sat),
    .height_sat   (height_sat),
    .crow_stride  (chroma_row_stride),
    .cpix_stride  (chroma_pixel_stride),
    .column       (column),
    .row          (row),
    .dest_index   (dest_index),
    .luma_index   (luma_index),
    .chroma_index (chroma_index)
  );

endmodule

FILE: tb/sv/tb_yuv420_to_rgba_rotate_core.sv
`timescale 1ns / 1ps

module tb_yuv420_to_rgba_rotate_core;

  localparam int unsigned MAX_DIM = 4096;
  localparam int LONG_HOLD = 80;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_REPORTS = 10;

  typedef logic [yuvrot_pkg::CFG_DATA_W-1:0] cfg_word_t;

  typedef struct packed {
    logic [yuvrot_pkg::COORD_W-1:0]  column;
    logic [yuvrot_pkg::COORD_W-1:0]  row;
    logic [yuvrot_pkg::SAMPLE_W-1:0] luma;
    logic [yuvrot_pkg::SAMPLE_W-1:0] chroma_u;
    logic [yuvrot_pkg::SAMPLE_W-1:0] chroma_v;
  } pixel_in_t;

  typedef struct packed {
    logic [yuvrot_pkg::PIXEL_W-1:0] pixel_word;
    logic [yuvrot_pkg::IDX_W-1:0]   dest_index;
    logic [yuvrot_pkg::IDX_W-1:0]   luma_index;
    logic [yuvrot_pkg::CIDX_W-1:0]  chroma_index;
  } pixel_out_t;

  // Converts accepted pixels and holds the converted words until they come out
  class pixel_scoreboard;
    logic [yuvrot_pkg::DIMREG_W-1:0] width_reg;
    logic [yuvrot_pkg::DIMREG_W-1:0] height_reg;
    logic [yuvrot_pkg::CROW_W-1:0]   crow_reg;
    logic [yuvrot_pkg::CPIX_W-1:0]   cpix_reg;
    pixel_out_t                      pending_pixels[$];
    int                              mismatches;

    function new();
      width_reg   = yuvrot_pkg::RST_FRAME_WIDTH;
      height_reg  = yuvrot_pkg::RST_FRAME_HEIGHT;
      crow_reg    = yuvrot_pkg::RST_CROW_STRIDE;
      cpix_reg    = yuvrot_pkg::RST_CPIX_STRIDE;
      mismatches  = 0;
    endfunction

    function void set_reg(yuvrot_pkg::cfg_reg_t idx, cfg_word_t data);
      case (idx)
        yuvrot_pkg::REG_FRAME_WIDTH:  width_reg  = data[yuvrot_pkg::DIMREG_W-1:0];
        yuvrot_pkg::REG_FRAME_HEIGHT: height_reg = data[yuvrot_pkg::DIMREG_W-1:0];
        yuvrot_pkg::REG_CROW_STRIDE:  crow_reg   = data[yuvrot_pkg::CROW_W-1:0];
        yuvrot_pkg::REG_CPIX_STRIDE:  cpix_reg   = data[yuvrot_pkg::CPIX_W-1:0];
        default: ;
      endcase
    endfunction

    // dimensions saturate at MAX_DIM before any index math
    function longint unsigned eff_width();
      return (width_reg > MAX_DIM) ? 64'(MAX_DIM) : 64'(width_reg);
    endfunction

    function longint unsigned eff_height();
      return (height_reg > MAX_DIM) ? 64'(MAX_DIM) : 64'(height_reg);
    endfunction

    function logic [7:0] clamp8(int v);
      if (v < 0) return 8'd0;
      if (v > 255) return 8'd255;
      return v[7:0];
    endfunction

    function pixel_out_t convert_pixel(pixel_in_t p);
      pixel_out_t res;
      int y, u, v, red, green, blue;
      longint unsigned w, h, col, rw, dst, lidx, cidx;
      y = int'(p.luma);
      u = int'(p.chroma_u);
      v = int'(p.chroma_v);
      // fixed-point color math, truncating shifts
      red   = y + ((v * int'(yuvrot_pkg::COEF_RV)) >>> 10) - int'(yuvrot_pkg::OFS_R);
      green = y - ((u * int'(yuvrot_pkg::COEF_GU)) >>> 17) + int'(yuvrot_pkg::OFS_G0)
                - ((v * int'(yuvrot_pkg::COEF_GV)) >>> 17) + int'(yuvrot_pkg::OFS_G1);
      blue  = y + ((u * int'(yuvrot_pkg::COEF_BU)) >>> 10) - int'(yuvrot_pkg::OFS_B);
      res.pixel_word = {yuvrot_pkg::ALPHA, clamp8(blue), clamp8(green), clamp8(red)};
      // addresses wrap at their field widths
      w = eff_width();
      h = eff_height();
      col = 64'(p.column);
      rw = 64'(p.row);
      dst = h * (col + 1) - (rw + 1);
      lidx = rw * w + col;
      cidx = 64'(cpix_reg) * (col >> 1) + 64'(crow_reg) * (rw >> 1);
      res.dest_index   = dst[yuvrot_pkg::IDX_W-1:0];
      res.luma_index   = lidx[yuvrot_pkg::IDX_W-1:0];
      res.chroma_index = cidx[yuvrot_pkg::CIDX_W-1:0];
      return res;
    endfunction

    function void note_input(pixel_in_t p);
      pending_pixels = {pending_pixels, convert_pixel(p)};
    endfunction

    function int pending();
      return pending_pixels.size();
    endfunction

    function void check_result(pixel_out_t got);
      pixel_out_t exp;
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("output beat with no pixel pending: word=%h dest=%h luma=%h chroma=%h",
                   got.pixel_word, got.dest_index, got.luma_index, got.chroma_index);
        return;
      end
      exp = pending_pixels.pop_front();
      if (got.pixel_word !== exp.pixel_word || got.dest_index !== exp.dest_index ||
          got.luma_index !== exp.luma_index || got.chroma_index !== exp.chroma_index) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("pixel mismatch %0d: exp word=%h dest=%h luma=%h chroma=%h",
                   mismatches, exp.pixel_word, exp.dest_index, exp.luma_index,
                   exp.chroma_index);
          $display("                   got word=%h dest=%h luma=%h chroma=%h",
                   got.pixel_word, got.dest_index, got.luma_index, got.chroma_index);
        end
      end
    endfunction
  endclass

  logic                              clk = 1'b0;
  logic                              rst;
  logic                              cfg_we;
  yuvrot_pkg::cfg_reg_t              cfg_index;
  cfg_word_t                         cfg_data;
  logic                              in_valid;
  logic                              in_ready;
  logic [yuvrot_pkg::COORD_W-1:0]    column;
  logic [yuvrot_pkg::COORD_W-1:0]    row;
  logic [yuvrot_pkg::SAMPLE_W-1:0]   luma;
  logic [yuvrot_pkg::SAMPLE_W-1:0]   chroma_u;
  logic [yuvrot_pkg::SAMPLE_W-1:0]   chroma_v;
  logic                              out_valid;
  logic                              out_ready;
  logic [yuvrot_pkg::PIXEL_W-1:0]    pixel_word;
  logic [yuvrot_pkg::IDX_W-1:0]      dest_index;
  logic [yuvrot_pkg::IDX_W-1:0]      luma_index;
  logic [yuvrot_pkg::CIDX_W-1:0]     chroma_index;

  pixel_scoreboard sb;
  bit hold_req = 1'b0;
  int idle_count;

  yuv420_to_rgba_rotate_core #(.MAX_DIM(MAX_DIM)) dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .column(column), .row(row), .luma(luma), .chroma_u(chroma_u), .chroma_v(chroma_v),
    .out_valid(out_valid), .out_ready(out_ready),
    .pixel_word(pixel_word), .dest_index(dest_index),
    .luma_index(luma_index), .chroma_index(chroma_index)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Output beat monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result(pixel_out_t'{pixel_word, dest_index, luma_index, chroma_index});
  end

  // Receiver: stall pattern changes per stretch; long hold-off on request
  initial begin : receiver
    int mode, span, hold_left;
    hold_left = 0;
    out_ready <= 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 150);
      for (int k = 0; k < span; k++) begin
        @(posedge clk);
        if (hold_req && hold_left == 0) begin
          hold_left = LONG_HOLD;
          hold_req = 1'b0;
        end
        if (hold_left > 0) begin
          out_ready <= 1'b0;
          hold_left--;
        end else begin
          case (mode)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            2: out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= ((k % 4) != 3);
          endcase
        end
      end
    end
  end

  // Watchdog: ends the run when nothing moves for too long
  initial begin
    idle_count = 0;
    while (idle_count < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || cfg_we || (in_valid && in_ready) || (out_valid && out_ready))
        idle_count = 0;
      else
        idle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  function automatic pixel_in_t pix(int c, int r, int y, int u, int v);
    pixel_in_t p;
    p.column   = c[yuvrot_pkg::COORD_W-1:0];
    p.row      = r[yuvrot_pkg::COORD_W-1:0];
    p.luma     = y[yuvrot_pkg::SAMPLE_W-1:0];
    p.chroma_u = u[yuvrot_pkg::SAMPLE_W-1:0];
    p.chroma_v = v[yuvrot_pkg::SAMPLE_W-1:0];
    return p;
  endfunction

  // Samples lean toward the rails now and then to hit the clamps
  function automatic logic [yuvrot_pkg::SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Mostly in-frame coordinates, the rest anywhere in the field range
  function automatic pixel_in_t random_pixel();
    pixel_in_t p;
    longint unsigned w, h;
    w = sb.eff_width();
    h = sb.eff_height();
    if (w != 0 && $urandom_range(0, 9) < 7) p.column = 12'($urandom_range(0, 32'(w - 1)));
    else p.column = 12'($urandom_range(0, 4095));
    if (h != 0 && $urandom_range(0, 9) < 7) p.row = 12'($urandom_range(0, 32'(h - 1)));
    else p.row = 12'($urandom_range(0, 4095));
    p.luma     = rand_sample();
    p.chroma_u = rand_sample();
    p.chroma_v = rand_sample();
    return p;
  endfunction

  // Offer one pixel; valid stays up so back-to-back beats need no toggle
  task automatic send_pixel(pixel_in_t p);
    in_valid <= 1'b1;
    column   <= p.column;
    row      <= p.row;
    luma     <= p.luma;
    chroma_u <= p.chroma_u;
    chroma_v <= p.chroma_v;
    do @(posedge clk); while (!in_ready);
    sb.note_input(p);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(yuvrot_pkg::cfg_reg_t idx, cfg_word_t data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  task automatic write_frame_config(cfg_word_t w, cfg_word_t h, cfg_word_t crs, cfg_word_t cps);
    write_reg(yuvrot_pkg::REG_FRAME_WIDTH, w);
    write_reg(yuvrot_pkg::REG_FRAME_HEIGHT, h);
    write_reg(yuvrot_pkg::REG_CROW_STRIDE, crs);
    write_reg(yuvrot_pkg::REG_CPIX_STRIDE, cps);
    cfg_we <= 1'b0;
  endtask

  // Random pixels in bursts with random gaps, or gapless when asked; can drain at the halfway point
  task automatic run_frame(int n_items, bit no_gaps, bit mid_drain);
    int sent, burst, gap;
    sent = 0;
    while (sent < n_items) begin
      burst = no_gaps ? n_items : $urandom_range(1, 40);
      for (int k = 0; k < burst && sent < n_items; k++) begin
        send_pixel(random_pixel());
        sent++;
        if (mid_drain && sent == n_items / 2) wait_for_results();
      end
      if (!no_gaps) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  endtask

  initial begin
    sb = new();
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_index <= yuvrot_pkg::REG_FRAME_WIDTH;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    column    <= '0;
    row       <= '0;
    luma      <= '0;
    chroma_u  <= '0;
    chroma_v  <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed pixels on the reset configuration: rails, clamps, wrapped dest
    send_pixel(pix(0, 0, 0, 0, 0));
    send_pixel(pix(4095, 4095, 255, 255, 255));
    send_pixel(pix(0, 4095, 128, 128, 128));
    send_pixel(pix(4095, 0, 0, 255, 0));
    send_pixel(pix(639, 479, 255, 0, 0));
    send_pixel(pix(1, 1, 0, 0, 255));
    send_pixel(pix(2, 3, 255, 0, 255));
    send_pixel(pix(3, 2, 0, 255, 0));
    send_pixel(pix(5, 7, 0, 255, 255));
    send_pixel(pix(12'hAAA, 12'h555, 8'hAA, 8'h55, 8'hAA));
    send_pixel(pix(12'h555, 12'hAAA, 8'h55, 8'hAA, 8'h55));
    send_pixel(pix(0, 479, 16, 128, 128));
    send_pixel(pix(640, 480, 235, 16, 240));
    send_pixel(pix(4095, 1, 255, 255, 0));
    run_frame(150, 1'b0, 1'b0);
    wait_for_results();

    // all registers zero
    write_frame_config(15'd0, 15'd0, 15'd0, 15'd0);
    run_frame(120, 1'b0, 1'b0);
    wait_for_results();

    // all data bits set: dims saturate, strides at their field max
    write_frame_config(15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF);
    run_frame(150, 1'b0, 1'b1);
    wait_for_results();

    // largest legal frame; receiver backs off so the pipe fills and stalls input
    write_frame_config(15'd4096, 15'd4096, 15'd16384, 15'd4);
    hold_req = 1'b1;
    run_frame(200, 1'b1, 1'b0);
    wait_for_results();

    // just past the saturation point, smallest strides
    write_frame_config(15'd4097, 15'd1, 15'd1, 15'd1);
    run_frame(120, 1'b0, 1'b0);
    wait_for_results();

    // random settings: two anywhere in the data field, two in the legal range
    for (int ph = 0; ph < 4; ph++) begin
      if (ph < 2)
        write_frame_config(cfg_word_t'($urandom_range(0, 32767)),
                           cfg_word_t'($urandom_range(0, 32767)),
                           cfg_word_t'($urandom_range(0, 32767)),
                           cfg_word_t'($urandom_range(0, 32767)));
      else
        write_frame_config(cfg_word_t'($urandom_range(1, 4096)),
                           cfg_word_t'($urandom_range(1, 4096)),
                           cfg_word_t'($urandom_range(1, 16384)),
                           cfg_word_t'($urandom_range(1, 4)));
      run_frame(150, 1'b0, 1'b0);
      wait_for_results();
    end

    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
